/* hdl/lpgc_pkg.sv */
`default_nettype none
package lpgc_pkg;

   localparam int CELL_WIDTH_DEF  = 2;
   localparam int CELL_HEIGHT_DEF = 4;

   localparam int COORD_W = 10;
   localparam int OFS_W   = 16;
   localparam int R2_W    = 32;
   localparam int MANT_W  = 31;
   localparam int FRAC_W  = 16;
   localparam int CORD_W  = 28;
   localparam int ANG_W   = 18;
   localparam int NSTEP   = 16;
   localparam int GLYPH_W = 3;
   localparam int CSR_W   = 16;
   localparam int CSR_A_W = 3;
   localparam int NSTAGE  = 3 + NSTEP + 3;

   localparam logic [14:0] LN2_HALF_Q16 = 15'd22713;
   localparam logic [10:0] SPOKE_W_TURN = 11'd1043;
   localparam logic [R2_W-1:0] SPOKE_MIN_R2 = 32'd9;

   typedef enum logic [CSR_A_W-1:0] {
      CSR_CENTER_COL      = 3'd0,
      CSR_CENTER_ROW      = 3'd1,
      CSR_RING_MIN_RADIUS = 3'd2,
      CSR_INV_LOG_STEP    = 3'd3,
      CSR_RING_WIDTH_FRAC = 3'd4,
      CSR_SPOKE_COUNT     = 3'd5
   } csr_index_type;

   typedef enum logic [GLYPH_W-1:0] {
      GLYPH_BLANK     = 3'd0,
      GLYPH_DASH      = 3'd1,
      GLYPH_BACKSLASH = 3'd2,
      GLYPH_BAR       = 3'd3,
      GLYPH_SLASH     = 3'd4,
      GLYPH_PLUS      = 3'd5
   } glyph_type;

   typedef struct packed {
      logic [9:0]  center_col;
      logic [9:0]  center_row;
      logic [15:0] ring_min_radius;
      logic [15:0] inv_log_step;
      logic [14:0] ring_width_frac;
      logic [5:0]  spoke_count;
   } cfg_type;

   typedef struct packed {
      logic [MANT_W-1:0]        ma;
      logic [MANT_W-1:0]        mb;
      logic [FRAC_W-1:0]        fa;
      logic [FRAC_W-1:0]        fb;
      logic [4:0]               pa;
      logic [4:0]               pb;
      logic signed [CORD_W-1:0] x;
      logic signed [CORD_W-1:0] y;
      logic signed [ANG_W-1:0]  z;
      logic                     ring_cand;
      logic                     spoke_cand;
   } iter_type;

   // atan(2^-i) in 2^-16 turn units
   function automatic logic [13:0] cordic_angle(input int i);
      logic [13:0] a;
      case (i)
         0: a = 14'd8192;
         1: a = 14'd4836;
         2: a = 14'd2555;
         3: a = 14'd1297;
         4: a = 14'd651;
         5: a = 14'd326;
         6: a = 14'd163;
         7: a = 14'd81;
         8: a = 14'd41;
         9: a = 14'd20;
         10: a = 14'd10;
         11: a = 14'd5;
         12: a = 14'd3;
         13: a = 14'd1;
         14: a = 14'd1;
         default: a = 14'd0;
      endcase
      return a;
   endfunction

endpackage
`default_nettype wire

/* hdl/lpgc_front.sv */
`default_nettype none
module lpgc_front #(
   parameter int CELL_WIDTH  = lpgc_pkg::CELL_WIDTH_DEF,
   parameter int CELL_HEIGHT = lpgc_pkg::CELL_HEIGHT_DEF
) (
   input  wire logic                          clock,
   input  wire logic [2:0]                    en,
   input  wire lpgc_pkg::cfg_type             cfg,
   input  wire logic [lpgc_pkg::COORD_W-1:0]  cell_row,
   input  wire logic [lpgc_pkg::COORD_W-1:0]  cell_col,
   output lpgc_pkg::iter_type                 stage_out
);
   import lpgc_pkg::*;

   localparam logic signed [OFS_W-1:0] XMUL = OFS_W'(CELL_WIDTH);
   localparam logic signed [OFS_W-1:0] YMUL = OFS_W'(CELL_HEIGHT);

   logic signed [OFS_W-1:0] diffx, diffy, dx_in, dy_in, dx_ff, dy_ff;
   logic signed [R2_W-1:0]  sqx, sqy;
   logic [R2_W-1:0]         r2_in, r2_ff, rr_in, rr_ff, rr_eff;
   logic signed [CORD_W-1:0] x0, y0, x0_ff, y0_ff;
   logic signed [ANG_W-1:0]  z0_ff;
   logic [4:0]               pa, pb;
   logic [R2_W-1:0]          sha, shb;
   iter_type                 out_in, out_ff;

   function automatic logic [4:0] msb_index(input logic [R2_W-1:0] v);
      logic [4:0] p;
      p = '0;
      for (int i = 0; i < R2_W; i++) begin
         if (v[i]) p = 5'(i);
      end
      return p;
   endfunction

   // stage 1: pixel offset from the centre
   always_comb begin
      diffx = $signed({6'b0, cell_col}) - $signed({6'b0, cfg.center_col});
      diffy = $signed({6'b0, cell_row}) - $signed({6'b0, cfg.center_row});
      dx_in = OFS_W'(diffx * XMUL);
      dy_in = OFS_W'(diffy * YMUL);
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         dx_ff <= dx_in;
         dy_ff <= dy_in;
      end
   end

   // stage 2: squared radius, squared inner radius, cordic preset
   always_comb begin
      sqx   = R2_W'(dx_ff * dx_ff);
      sqy   = R2_W'(dy_ff * dy_ff);
      r2_in = R2_W'(sqx) + R2_W'(sqy);
      rr_in = R2_W'(cfg.ring_min_radius * cfg.ring_min_radius);
      x0    = {{(CORD_W-OFS_W-8){dx_ff[OFS_W-1]}}, dx_ff, 8'b0};
      y0    = {{(CORD_W-OFS_W-8){dy_ff[OFS_W-1]}}, dy_ff, 8'b0};
   end

   always_ff @(posedge clock) begin
      if (en[1]) begin
         r2_ff  <= r2_in;
         rr_ff  <= rr_in;
         x0_ff  <= dx_ff[OFS_W-1] ? -x0 : x0;
         y0_ff  <= dx_ff[OFS_W-1] ? -y0 : y0;
         z0_ff  <= dx_ff[OFS_W-1] ? ANG_W'(32768) : '0;
      end
   end

   // stage 3: normalize both log arguments to q1.30
   always_comb begin
      rr_eff = (rr_ff == '0) ? R2_W'(1) : rr_ff;
      pa     = msb_index(r2_ff);
      pb     = msb_index(rr_eff);
      sha    = r2_ff << (5'd31 - pa);
      shb    = rr_eff << (5'd31 - pb);
      out_in.ma = sha[R2_W-1:1];
      out_in.mb = shb[R2_W-1:1];
      out_in.fa = '0;
      out_in.fb = '0;
      out_in.pa = pa;
      out_in.pb = pb;
      out_in.x  = x0_ff;
      out_in.y  = y0_ff;
      out_in.z  = z0_ff;
      out_in.ring_cand  = {r2_ff, 16'b0} > {16'b0, rr_ff};
      out_in.spoke_cand = r2_ff > SPOKE_MIN_R2;
   end

   always_ff @(posedge clock) begin
      if (en[2]) begin
         out_ff <= out_in;
      end
   end

   assign stage_out = out_ff;

endmodule
`default_nettype wire

/* hdl/lpgc_iter.sv */
`default_nettype none
module lpgc_iter #(
   parameter int STEP = 0
) (
   input  wire logic               clock,
   input  wire logic               en,
   input  wire lpgc_pkg::iter_type stage_in,
   output lpgc_pkg::iter_type      stage_out
);
   import lpgc_pkg::*;

   logic [2*MANT_W-1:0]      sqa, sqb;
   logic [MANT_W:0]          sa, sb;
   logic signed [CORD_W-1:0] xs, ys;
   logic signed [ANG_W-1:0]  ang;
   iter_type                 out_in, out_ff;

   always_comb begin
      out_in = stage_in;
      // one squaring yields one fraction bit of log2
      sqa = (2*MANT_W)'(stage_in.ma * stage_in.ma);
      sqb = (2*MANT_W)'(stage_in.mb * stage_in.mb);
      sa  = sqa[2*MANT_W-1:MANT_W-1];
      sb  = sqb[2*MANT_W-1:MANT_W-1];
      out_in.fa = {stage_in.fa[FRAC_W-2:0], sa[MANT_W]};
      out_in.fb = {stage_in.fb[FRAC_W-2:0], sb[MANT_W]};
      out_in.ma = sa[MANT_W] ? sa[MANT_W:1] : sa[MANT_W-1:0];
      out_in.mb = sb[MANT_W] ? sb[MANT_W:1] : sb[MANT_W-1:0];
      // one cordic vectoring step
      xs  = stage_in.x >>> STEP;
      ys  = stage_in.y >>> STEP;
      ang = ANG_W'(cordic_angle(STEP));
      if (stage_in.y > 0) begin
         out_in.x = stage_in.x + ys;
         out_in.y = stage_in.y - xs;
         out_in.z = stage_in.z + ang;
      end else begin
         out_in.x = stage_in.x - ys;
         out_in.y = stage_in.y + xs;
         out_in.z = stage_in.z - ang;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         out_ff <= out_in;
      end
   end

   assign stage_out = out_ff;

endmodule
`default_nettype wire

/* hdl/lpgc_back.sv */
`default_nettype none
module lpgc_back (
   input  wire logic                          clock,
   input  wire logic [2:0]                    en,
   input  wire lpgc_pkg::cfg_type             cfg,
   input  wire lpgc_pkg::iter_type            stage_in,
   output logic [lpgc_pkg::GLYPH_W-1:0]       glyph
);
   import lpgc_pkg::*;

   logic [21:0] la, lb, d;
   logic [36:0] p1_in, p1_ff;
   logic [15:0] t_ff;
   logic        ring_c1_ff, spoke_c1_ff;
   logic [43:0] u;
   logic [21:0] tp;
   logic [16:0] w, p17;
   logic        spoke_hit_in, spoke_hit_ff, ring_c2_ff;
   logic [15:0] f_ff;
   logic [14:0] h_ff;
   logic        ring_hit;
   glyph_type   glyph_in;
   logic [GLYPH_W-1:0] glyph_ff;

   // stage 1: log difference times ln2/2
   always_comb begin
      la    = {6'(stage_in.pa) + 6'd16, stage_in.fa};
      lb    = {1'b0, stage_in.pb, stage_in.fb};
      d     = (la > lb) ? la - lb : '0;
      p1_in = 37'(d * LN2_HALF_Q16);
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         p1_ff       <= p1_in;
         t_ff        <= stage_in.z[15:0];
         ring_c1_ff  <= stage_in.ring_cand;
         spoke_c1_ff <= stage_in.spoke_cand;
      end
   end

   // stage 2: ring phase, spoke test
   always_comb begin
      u   = 44'(p1_ff * cfg.inv_log_step);
      tp  = 22'(t_ff * cfg.spoke_count);
      w   = 17'(cfg.spoke_count * SPOKE_W_TURN);
      p17 = {1'b0, tp[15:0]};
      spoke_hit_in = spoke_c1_ff && ((p17 < w) || (p17 > 17'h10000 - w));
   end

   always_ff @(posedge clock) begin
      if (en[1]) begin
         f_ff         <= u[43:28];
         h_ff         <= t_ff[14:0];
         ring_c2_ff   <= ring_c1_ff;
         spoke_hit_ff <= spoke_hit_in;
      end
   end

   // stage 3: ring test and glyph choice
   always_comb begin
      ring_hit = ring_c2_ff && (({1'b0, f_ff} < {2'b0, cfg.ring_width_frac}) ||
                 ({1'b0, f_ff} > 17'h10000 - {2'b0, cfg.ring_width_frac}));
      if (ring_hit && spoke_hit_ff) begin
         glyph_in = GLYPH_PLUS;
      end else if (ring_hit || spoke_hit_ff) begin
         if (h_ff < 15'd4096 || h_ff >= 15'd28672) glyph_in = GLYPH_DASH;
         else if (h_ff < 15'd12288) glyph_in = GLYPH_BACKSLASH;
         else if (h_ff < 15'd20480) glyph_in = GLYPH_BAR;
         else glyph_in = GLYPH_SLASH;
      end else begin
         glyph_in = GLYPH_BLANK;
      end
   end

   always_ff @(posedge clock) begin
      if (en[2]) begin
         glyph_ff <= glyph_in;
      end
   end

   assign glyph = glyph_ff;

endmodule
`default_nettype wire

/* hdl/log_polar_grid_classifier.sv */
`default_nettype none
// Log-polar grid classifier: takes one character cell per transaction and returns its
// glyph (blank, dash, backslash, bar, slash or plus). Fully pipelined: one cell enters
// each clock while req_tready is high, and its glyph appears after the front stages,
// the 16 steps of the log2 squaring chain, which run in lockstep with the 16 cordic
// angle steps, and the back stages. Each stage moves on only when the stage after it
// is empty or moving, so a stalled result holds only the stages behind it that are full.
// Configuration is read live and should only be written while no cell is in flight.
module log_polar_grid_classifier #(
   parameter int CELL_WIDTH  = lpgc_pkg::CELL_WIDTH_DEF,
   parameter int CELL_HEIGHT = lpgc_pkg::CELL_HEIGHT_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          csr_we,
   input  wire logic [lpgc_pkg::CSR_A_W-1:0]  csr_addr,
   input  wire logic [lpgc_pkg::CSR_W-1:0]    csr_wdata,
   input  wire logic                          req_tvalid,
   output logic                               req_tready,
   input  wire logic [23:0]                   req_tdata,   // cell_row, cell_col
   output logic                               rsp_tvalid,
   input  wire logic                          rsp_tready,
   output logic [7:0]                         rsp_tdata    // glyph
);
   import lpgc_pkg::*;

   cfg_type             cfg_ff;
   logic [NSTAGE-1:0]   valid_ff, valid_in, en;
   iter_type            chain [0:NSTEP];
   logic [GLYPH_W-1:0]  glyph;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.center_col      <= 10'd40;
         cfg_ff.center_row      <= 10'd12;
         cfg_ff.ring_min_radius <= 16'd1024;
         cfg_ff.inv_log_step    <= 16'd16384;
         cfg_ff.ring_width_frac <= 15'd5243;
         cfg_ff.spoke_count     <= 6'd12;
      end else if (csr_we) begin
         case (csr_addr)
            CSR_CENTER_COL:      cfg_ff.center_col      <= csr_wdata[9:0];
            CSR_CENTER_ROW:      cfg_ff.center_row      <= csr_wdata[9:0];
            CSR_RING_MIN_RADIUS: cfg_ff.ring_min_radius <= csr_wdata;
            CSR_INV_LOG_STEP:    cfg_ff.inv_log_step    <= csr_wdata;
            CSR_RING_WIDTH_FRAC: cfg_ff.ring_width_frac <= csr_wdata[14:0];
            CSR_SPOKE_COUNT:     cfg_ff.spoke_count     <= csr_wdata[5:0];
            default: ;
         endcase
      end
   end

   // a stage may load when it is empty or its contents move on
   always_comb begin
      en[NSTAGE-1] = !valid_ff[NSTAGE-1] || rsp_tready;
      for (int k = NSTAGE-2; k >= 0; k--) begin
         en[k] = !valid_ff[k] || en[k+1];
      end
      valid_in[0] = en[0] ? req_tvalid : valid_ff[0];
      for (int k = 1; k < NSTAGE; k++) begin
         valid_in[k] = en[k] ? valid_ff[k-1] : valid_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   lpgc_front #(.CELL_WIDTH(CELL_WIDTH), .CELL_HEIGHT(CELL_HEIGHT)) u_front (
      .clock     (clock),
      .en        (en[2:0]),
      .cfg       (cfg_ff),
      .cell_row  (req_tdata[9:0]),
      .cell_col  (req_tdata[19:10]),
      .stage_out (chain[0])
   );

   for (genvar s = 0; s < NSTEP; s++) begin : g_iter
      lpgc_iter #(.STEP(s)) u_iter (
         .clock     (clock),
         .en        (en[3+s]),
         .stage_in  (chain[s]),
         .stage_out (chain[s+1])
      );
   end

   lpgc_back u_back (
      .clock    (clock),
      .en       (en[NSTAGE-1:NSTAGE-3]),
      .cfg      (cfg_ff),
      .stage_in (chain[NSTEP]),
      .glyph    (glyph)
   );

   assign req_tready = en[0];
   assign rsp_tvalid = valid_ff[NSTAGE-1];
   assign rsp_tdata  = {5'b0, glyph};

   a_glyph_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> glyph <= GLYPH_PLUS)
      else $error("glyph code out of range");

   a_empty_out_ready: assert property (@(posedge clock) disable iff (reset)
      !valid_ff[NSTAGE-1] |-> req_tready)
      else $error("input stalled with empty output stage");

   a_accept_loads: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> valid_ff[0])
      else $error("accepted cell not captured");

endmodule
`default_nettype wire

/* test/lpgc_checker.sv */
`timescale 1ns / 1ps
module lpgc_checker (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           csr_we,
   input  wire logic [lpgc_pkg::CSR_A_W-1:0]   csr_addr,
   input  wire logic [lpgc_pkg::CSR_W-1:0]     csr_wdata,
   input  wire logic                           req_tvalid,
   input  wire logic                           req_tready,
   input  wire logic [23:0]                    req_tdata,
   input  wire logic                           rsp_tvalid,
   input  wire logic                           rsp_tready,
   input  wire logic [7:0]                     rsp_tdata,
   output int                                  fail_count,
   output int                                  glyphs_pending
);
   import lpgc_pkg::*;

   cfg_type grid_cfg;
   glyph_type glyph_queue[$];

   // floor log2 plus 16 fraction bits from squaring the mantissa
   function automatic longint unsigned log2_fix(longint unsigned x);
      int p;
      longint unsigned m;
      longint unsigned frac;
      if (x == 0) x = 1;
      p = 0;
      while (p < 63 && (x >> (p + 1)) != 0) p++;
      m = (p > 30) ? (x >> (p - 30)) : (x << (30 - p));
      frac = 0;
      for (int i = 0; i < 16; i++) begin
         m = (m * m) >> 30;
         frac = frac << 1;
         if (m >= (64'd2 << 30)) begin
            frac = frac | 1;
            m = m >> 1;
         end
      end
      return (longint'(p) << 16) | frac;
   endfunction

   function automatic longint atan_step(int i);
      case (i)
         0: return 8192;   1: return 4836;  2: return 2555;  3: return 1297;
         4: return 651;    5: return 326;   6: return 163;   7: return 81;
         8: return 41;     9: return 20;    10: return 10;   11: return 5;
         12: return 3;     13: return 1;    14: return 1;    default: return 0;
      endcase
   endfunction

   function automatic longint unsigned turn_angle(longint dx, longint dy);
      longint x;
      longint y;
      longint z;
      longint xs;
      longint ys;
      x = dx * 256;
      y = dy * 256;
      z = 0;
      if (x < 0) begin
         x = -x;
         y = -y;
         z = 32768;
      end
      for (int i = 0; i < 16; i++) begin
         xs = x >>> i;
         ys = y >>> i;
         if (y > 0) begin
            x = x + ys; y = y - xs; z = z + atan_step(i);
         end else begin
            x = x - ys; y = y + xs; z = z - atan_step(i);
         end
      end
      return longint'(z) & 64'hFFFF;
   endfunction

   function automatic glyph_type classify_cell(logic [9:0] row, logic [9:0] col);
      longint dx;
      longint dy;
      longint unsigned r2;
      longint unsigned rr;
      longint unsigned a;
      longint unsigned la;
      longint unsigned lb;
      longint unsigned d;
      longint unsigned u;
      longint unsigned f;
      longint unsigned t;
      longint p;
      longint w;
      longint h;
      bit on_ring;
      bit near_spoke;
      dx = (longint'(col) - longint'(grid_cfg.center_col)) * 2;
      dy = (longint'(row) - longint'(grid_cfg.center_row)) * 4;
      r2 = dx * dx + dy * dy;
      rr = longint'(grid_cfg.ring_min_radius) * longint'(grid_cfg.ring_min_radius);
      a = r2 << 16;
      t = turn_angle(dx, dy);
      on_ring = 0;
      near_spoke = 0;
      if (a > rr) begin
         la = log2_fix(a);
         lb = log2_fix(rr == 0 ? 1 : rr);
         d = (la > lb) ? la - lb : 0;
         u = (d * 22713 * longint'(grid_cfg.inv_log_step)) >> 28;
         f = u & 64'hFFFF;
         on_ring = (f < grid_cfg.ring_width_frac) ||
                   (longint'(f) > 65536 - longint'(grid_cfg.ring_width_frac));
      end
      if (r2 > 9) begin
         p = longint'((t * grid_cfg.spoke_count) & 64'hFFFF);
         w = longint'(grid_cfg.spoke_count) * 1043;
         near_spoke = (p < w) || (p > 65536 - w);
      end
      if (on_ring && near_spoke) return GLYPH_PLUS;
      if (!(on_ring || near_spoke)) return GLYPH_BLANK;
      h = longint'(t) & 32'h7FFF;
      if (h < 4096 || h >= 28672) return GLYPH_DASH;
      if (h < 12288) return GLYPH_BACKSLASH;
      if (h < 20480) return GLYPH_BAR;
      return GLYPH_SLASH;
   endfunction

   always @(posedge clock) begin
      glyph_type want;
      if (reset) begin
         grid_cfg.center_col <= 10'd40;
         grid_cfg.center_row <= 10'd12;
         grid_cfg.ring_min_radius <= 16'd1024;
         grid_cfg.inv_log_step <= 16'd16384;
         grid_cfg.ring_width_frac <= 15'd5243;
         grid_cfg.spoke_count <= 6'd12;
         glyph_queue.delete();
         glyphs_pending <= 0;
         fail_count <= 0;
      end else begin
         if (csr_we) begin
            case (csr_addr)
               CSR_CENTER_COL:      grid_cfg.center_col <= csr_wdata[9:0];
               CSR_CENTER_ROW:      grid_cfg.center_row <= csr_wdata[9:0];
               CSR_RING_MIN_RADIUS: grid_cfg.ring_min_radius <= csr_wdata;
               CSR_INV_LOG_STEP:    grid_cfg.inv_log_step <= csr_wdata;
               CSR_RING_WIDTH_FRAC: grid_cfg.ring_width_frac <= csr_wdata[14:0];
               CSR_SPOKE_COUNT:     grid_cfg.spoke_count <= csr_wdata[5:0];
               default: ;
            endcase
         end
         if (req_tvalid && req_tready)
            glyph_queue.push_back(classify_cell(req_tdata[9:0], req_tdata[19:10]));
         if (rsp_tvalid && rsp_tready) begin
            if (glyph_queue.size() == 0) begin
               if (fail_count < 10)
                  $display("unexpected result transaction: glyph %0d", rsp_tdata[2:0]);
               fail_count <= fail_count + 1;
            end else begin
               want = glyph_queue.pop_front();
               if (rsp_tdata[2:0] !== want) begin
                  if (fail_count < 10)
                     $display("glyph mismatch: expected %0d actual %0d", want,
                              rsp_tdata[2:0]);
                  fail_count <= fail_count + 1;
               end
            end
         end
         glyphs_pending <= glyph_queue.size();
      end
   end

endmodule

/* test/testbench.sv */
`timescale 1ns / 1ps
module testbench;
   import lpgc_pkg::*;

   logic clock;
   logic reset;
   logic csr_we;
   logic [CSR_A_W-1:0] csr_addr;
   logic [CSR_W-1:0] csr_wdata;
   logic req_tvalid;
   logic req_tready;
   logic [23:0] req_tdata;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [7:0] rsp_tdata;
   int fail_count;
   int glyphs_pending;
   logic hold_start;
   int hold_left = 0;
   int stall_mode = 0;
   int stall_left = 0;
   int cur_row;
   int cur_col;

   log_polar_grid_classifier dut (
      .clock(clock), .reset(reset),
      .csr_we(csr_we), .csr_addr(csr_addr), .csr_wdata(csr_wdata),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
   );

   lpgc_checker u_checker (
      .clock(clock), .reset(reset),
      .csr_we(csr_we), .csr_addr(csr_addr), .csr_wdata(csr_wdata),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .fail_count(fail_count), .glyphs_pending(glyphs_pending)
   );

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   initial begin
      #5ms;
      $display("TEST FAILED");
      $finish;
   end

   // receiver: changing stall pattern plus one long hold-off
   always @(posedge clock) begin
      if (hold_start) hold_left <= 400;
      else if (hold_left > 0) hold_left <= hold_left - 1;
      if (stall_left == 0) begin
         stall_mode <= $urandom_range(0, 3);
         stall_left <= $urandom_range(20, 120);
      end else begin
         stall_left <= stall_left - 1;
      end
      if (hold_start || hold_left > 1) rsp_tready <= 0;
      else case (stall_mode)
         0: rsp_tready <= 1;
         1: rsp_tready <= $urandom_range(0, 1);
         2: rsp_tready <= ($urandom_range(0, 3) == 0);
         default: rsp_tready <= ($urandom_range(0, 7) != 0);
      endcase
   end

   task automatic send_cell(int row, int col);
      req_tvalid <= 1;
      req_tdata <= {4'd0, 10'(col), 10'(row)};
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic pause_sender(int n);
      req_tvalid <= 0;
      repeat (n) @(posedge clock);
   endtask

   task automatic drain();
      req_tvalid <= 0;
      @(posedge clock);
      while (glyphs_pending != 0) @(posedge clock);
      repeat (30) @(posedge clock);
   endtask

   // write enable stays high across back to back writes, the caller drops it
   task automatic write_reg(logic [CSR_A_W-1:0] idx, int value);
      csr_we <= 1;
      csr_addr <= idx;
      csr_wdata <= 16'(value);
      @(posedge clock);
      if (idx == CSR_CENTER_COL) cur_col = value & 10'h3FF;
      if (idx == CSR_CENTER_ROW) cur_row = value & 10'h3FF;
   endtask

   task automatic write_grid(int ccol, int crow, int rad, int inv, int width, int spokes);
      write_reg(CSR_CENTER_COL, ccol);
      write_reg(CSR_CENTER_ROW, crow);
      write_reg(CSR_RING_MIN_RADIUS, rad);
      write_reg(CSR_INV_LOG_STEP, inv);
      write_reg(CSR_RING_WIDTH_FRAC, width);
      write_reg(CSR_SPOKE_COUNT, spokes);
   endtask

   function automatic int clamp_coord(int v);
      if (v < 0) return 0;
      if (v > 1023) return 1023;
      return v;
   endfunction

   task automatic send_directed();
      send_cell(cur_row, cur_col);
      send_cell(0, 0);
      send_cell(1023, 1023);
      send_cell(0, 1023);
      send_cell(1023, 0);
      send_cell(clamp_coord(cur_row + 1), cur_col);
      send_cell(cur_row, clamp_coord(cur_col + 1));
      send_cell(clamp_coord(cur_row - 1), clamp_coord(cur_col - 1));
      send_cell(cur_row, clamp_coord(cur_col + 20));
      send_cell(clamp_coord(cur_row - 10), cur_col);
   endtask

   initial begin
      int burst;
      reset = 1;
      csr_we = 0;
      csr_addr = CSR_CENTER_COL;
      csr_wdata = 0;
      req_tvalid = 0;
      req_tdata = 0;
      hold_start = 0;
      cur_row = 12;
      cur_col = 40;
      repeat (10) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      for (int phase = 0; phase < 10; phase++) begin
         if (phase == 1) begin
            // zero radius, no spokes, widest rings
            write_grid(0, 0, 0, 40960, 32767, 0);
         end else if (phase == 2) begin
            // far corner centre, thinnest rings, spokes wide enough to cover all
            write_grid(1023, 1023, 65535, 6827, 0, 63);
            write_reg(3'(CSR_SPOKE_COUNT + 1), 16'hFFFF);
            write_reg(3'(CSR_SPOKE_COUNT + 2), 16'h0000);
         end else if (phase == 3) begin
            write_grid(512, 300, 256, 40960, 5243, 36);
         end else if (phase == 4) begin
            write_grid(1023 - $urandom_range(0, 80), $urandom_range(0, 30), 300, 6827,
                       $urandom_range(0, 32767), 4);
         end else if (phase > 4) begin
            write_grid($urandom_range(0, 1023), $urandom_range(0, 1023),
                       $urandom_range(256, 4096), $urandom_range(6827, 40960),
                       $urandom_range(0, 32767), $urandom_range(4, 36));
         end
         csr_we <= 0;
         if (phase < 3) send_directed();
         if (phase == 3) begin
            hold_start <= 1;
            @(posedge clock);
            hold_start <= 0;
         end
         for (int n = 0; n < 95; ) begin
            burst = $urandom_range(1, 30);
            for (int b = 0; b < burst && n < 95; b++, n++) begin
               if ($urandom_range(0, 9) < 7)
                  send_cell(clamp_coord(cur_row + $urandom_range(0, 40) - 20),
                            clamp_coord(cur_col + $urandom_range(0, 80) - 40));
               else
                  send_cell($urandom_range(0, 1023), $urandom_range(0, 1023));
            end
            if ($urandom_range(0, 2) != 0) pause_sender($urandom_range(1, 12));
         end
         if (phase == 6) begin
            // sender waits for every glyph before going on
            drain();
            send_cell(cur_row, clamp_coord(cur_col + 3));
         end
         drain();
      end
      if (fail_count == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule
